// ===== design/plac_pkg.sv =====
// plac_pkg: payload structs, configuration struct, mode codes and register map
// for the pressure leak alarm controller; no dependencies
`default_nettype none

package plac_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, address = 4 * index
   localparam logic [2:0] REG_IDLE_LEVEL    = 3'd0;
   localparam logic [2:0] REG_ON_OFF_LEVEL  = 3'd1;
   localparam logic [2:0] REG_HYSTERESIS    = 3'd2;
   localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd3;
   localparam logic [2:0] REG_SOUND_TICKS   = 3'd4;
   localparam logic [2:0] REG_BATTERY_LIMIT = 3'd5;

   // register reset values
   localparam logic [15:0] IDLE_LEVEL_RST    = 16'd983;
   localparam logic [15:0] ON_OFF_LEVEL_RST  = 16'd913;
   localparam logic [7:0]  HYSTERESIS_RST    = 8'd10;
   localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd240;
   localparam logic [7:0]  SOUND_TICKS_RST   = 8'd40;
   localparam logic [7:0]  BATTERY_LIMIT_RST = 8'd104;

   // mode codes as seen on the result beat
   localparam logic [2:0] MODE_DOWN        = 3'd0;
   localparam logic [2:0] MODE_IDLE        = 3'd1;
   localparam logic [2:0] MODE_IDLE_LOWBAT = 3'd2;
   localparam logic [2:0] MODE_OK          = 3'd3;
   localparam logic [2:0] MODE_ALARM       = 3'd4;
   localparam logic [2:0] MODE_SILENT      = 3'd5;

   typedef struct packed {
      logic [15:0] pressure;
      logic [7:0]  battery_code;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        red_led;
      logic        green_led;
      logic        lamp_clock_enable;
      logic        tone_enable;
      logic        buzzer_drive;
      logic        battery_low;
      logic [15:0] current_alarm_level;
   } rsp_type;

   typedef struct packed {
      logic [15:0] idle_level;
      logic [15:0] on_off_level;
      logic [7:0]  alarm_hysteresis;
      logic [15:0] idle_timeout_ticks;
      logic [7:0]  alarm_sound_ticks;
      logic [7:0]  battery_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/pressure_leak_alarm_controller.sv =====
// pressure_leak_alarm_controller: top level with input and result registers
// depends on plac_pkg, plac_csr, plac_core
//
// Each req beat is one 250 ms tick: a pressure sample and a battery code.
// Each tick gives exactly one rsp beat: mode, lamp and buzzer drives, the
// sticky low battery flag and the present alarm level.
// A req beat lands in the input register when accepted; the mode machine
// steps and the result lands in the result register once that register is
// empty or rsp_ready is high. One tick per cycle is sustained while rsp_ready
// stays high: the machine step is a single pass of compares and a 17-bit add.
// When rsp_ready is low the result register holds its beat and the input
// register takes one more beat; req_ready then drops until the result moves.
// Registers sit behind an apb-style port (pready tied high) at byte address
// 4 * index, to be written by the user while no tick is in flight, unchecked.
// Reset (synchronous) empties both registers, puts the machine in idle with
// counters, alarm level and battery flag cleared and loads register defaults.
`default_nettype none

module pressure_leak_alarm_controller
   import plac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type  cfg;
   req_type  in_data_ff;
   logic     in_valid_ff, in_valid_in;
   rsp_type  out_data_ff;
   rsp_type  core_rsp;
   logic     out_valid_ff, out_valid_in;
   logic     advance;

   plac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   plac_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   assign advance      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready    = ~in_valid_ff | advance;
   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= core_rsp;
   end

endmodule

`default_nettype wire

// ===== design/plac_csr.sv =====
// plac_csr: configuration register bank behind an apb-style port
// depends on plac_pkg
`default_nettype none

module plac_csr
   import plac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  index;
   logic        write_en;

   assign index    = paddr[4:2];
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_IDLE_LEVEL:    cfg_in.idle_level         = pwdata[15:0];
            REG_ON_OFF_LEVEL:  cfg_in.on_off_level       = pwdata[15:0];
            REG_HYSTERESIS:    cfg_in.alarm_hysteresis   = pwdata[7:0];
            REG_IDLE_TIMEOUT:  cfg_in.idle_timeout_ticks = pwdata[15:0];
            REG_SOUND_TICKS:   cfg_in.alarm_sound_ticks  = pwdata[7:0];
            REG_BATTERY_LIMIT: cfg_in.battery_limit      = pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_IDLE_LEVEL:    prdata = {16'h0000, cfg_ff.idle_level};
         REG_ON_OFF_LEVEL:  prdata = {16'h0000, cfg_ff.on_off_level};
         REG_HYSTERESIS:    prdata = {24'h000000, cfg_ff.alarm_hysteresis};
         REG_IDLE_TIMEOUT:  prdata = {16'h0000, cfg_ff.idle_timeout_ticks};
         REG_SOUND_TICKS:   prdata = {24'h000000, cfg_ff.alarm_sound_ticks};
         REG_BATTERY_LIMIT: prdata = {24'h000000, cfg_ff.battery_limit};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_level         <= IDLE_LEVEL_RST;
         cfg_ff.on_off_level       <= ON_OFF_LEVEL_RST;
         cfg_ff.alarm_hysteresis   <= HYSTERESIS_RST;
         cfg_ff.idle_timeout_ticks <= IDLE_TIMEOUT_RST;
         cfg_ff.alarm_sound_ticks  <= SOUND_TICKS_RST;
         cfg_ff.battery_limit      <= BATTERY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/plac_core.sv =====
// plac_core: mode machine, tick counter, alarm level and battery flag,
// forms one result per processed tick; depends on plac_pkg
`default_nettype none

module plac_core
   import plac_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  req_type      req,
   input  cfg_type      cfg,
   output rsp_type      rsp
);

   typedef enum logic [2:0] {
      ST_DOWN        = MODE_DOWN,
      ST_IDLE        = MODE_IDLE,
      ST_IDLE_LOWBAT = MODE_IDLE_LOWBAT,
      ST_OK          = MODE_OK,
      ST_ALARM       = MODE_ALARM,
      ST_SILENT      = MODE_SILENT
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] level_ff, level_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic        low_bat_ff, low_bat_in;

   logic [16:0] sum;
   logic [15:0] sat_level;
   logic [15:0] tick_seen;
   logic        red, green, blink, alt;
   logic        lamp_red, lamp_green;

   assign sum       = {1'b0, req.pressure} + {9'h000, cfg.alarm_hysteresis};
   assign sat_level = sum[16] ? 16'hffff : sum[15:0];

   always_comb begin
      low_bat_in   = low_bat_ff
                   | ((tick_ff[4:0] == 5'd0) && (req.battery_code > cfg.battery_limit));
      state_in     = state_ff;
      tick_seen    = tick_ff;
      level_in     = level_ff;
      countdown_in = countdown_ff;

      unique case (state_ff)
         ST_IDLE, ST_IDLE_LOWBAT: begin
            if (state_ff == ST_IDLE && low_bat_in) state_in = ST_IDLE_LOWBAT;
            if (req.pressure < cfg.on_off_level) begin
               level_in = sat_level;
               state_in = ST_OK;
            end else if (tick_ff >= cfg.idle_timeout_ticks) begin
               state_in = ST_DOWN;
            end
         end
         ST_OK: begin
            if (req.pressure > level_ff) begin
               countdown_in = cfg.alarm_sound_ticks;
               state_in     = ST_ALARM;
            end else if (sum < {1'b0, level_ff}) begin
               level_in = sat_level;
            end
         end
         ST_ALARM, ST_SILENT: begin
            if (state_ff == ST_ALARM) begin
               countdown_in = countdown_ff - 8'd1;
               if (countdown_in == 8'd0) state_in = ST_SILENT;
            end
            if (req.pressure > cfg.on_off_level) begin
               level_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_DOWN;
            tick_seen = '0;
            if (req.pressure < cfg.idle_level) state_in = ST_IDLE;
         end
      endcase

      tick_in = tick_seen + 16'd1;

      red   = 1'b0;
      green = 1'b0;
      blink = 1'b0;
      alt   = 1'b0;
      case (state_in)
         ST_IDLE:        begin green = 1'b1; blink = 1'b1; end
         ST_IDLE_LOWBAT: begin red = 1'b1; alt = 1'b1; end
         ST_OK:          green = 1'b1;
         ST_ALARM:       begin red = 1'b1; blink = 1'b1; end
         ST_SILENT:      begin red = 1'b1; blink = 1'b1; end
         default:        ;
      endcase

      lamp_red   = red & ~green;
      lamp_green = green;
      if (tick_seen[1:0] != 2'd0) begin
         if (blink) begin
            lamp_red   = 1'b0;
            lamp_green = 1'b0;
         end
         if (alt) begin
            lamp_red   = 1'b0;
            lamp_green = 1'b1;
         end
      end

      rsp.mode                = state_in;
      rsp.red_led             = lamp_red;
      rsp.green_led           = lamp_green;
      rsp.lamp_clock_enable   = (state_in != ST_DOWN);
      rsp.tone_enable         = (state_in == ST_ALARM);
      rsp.buzzer_drive        = (state_in == ST_ALARM) & tick_seen[1];
      rsp.battery_low         = low_bat_in;
      rsp.current_alarm_level = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         level_ff     <= '0;
         countdown_ff <= '0;
         low_bat_ff   <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         level_ff     <= level_in;
         countdown_ff <= countdown_in;
         low_bat_ff   <= low_bat_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/plac_checker.sv =====
// plac_checker: port-level assertions for the pressure leak alarm controller
// and the bind that attaches them; depends on plac_pkg
`default_nettype none

module plac_checker
   import plac_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input rsp_type   rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // lamp timer runs whenever not powered down
   a_lamp_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.lamp_clock_enable == (rsp_data.mode != MODE_DOWN))
      else $error("lamp clock enable disagrees with mode");

   // buzzer only sounds in alarm
   a_buzzer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer_drive |->
         rsp_data.tone_enable && rsp_data.mode == MODE_ALARM)
      else $error("buzzer driven outside alarm");

   // both lamps never lit together
   a_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.red_led && rsp_data.green_led))
      else $error("red and green lamps both on");

   // low battery flag stays set until reset
   a_battery_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.battery_low |=> !rsp_valid || rsp_data.battery_low)
      else $error("low battery flag cleared");

endmodule

bind pressure_leak_alarm_controller plac_checker u_plac_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
